// File: rtl/mbf_pkg.sv
package mbf_pkg;

  localparam logic       MODE_HEADER = 1'b0;
  localparam logic       MODE_DATA   = 1'b1;

  localparam logic [7:0] FUNC_READ   = 8'h03;
  localparam logic [7:0] FUNC_WRITE  = 8'h06;

  localparam logic [7:0] CHAR_COLON  = 8'h3a;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_LF     = 8'h0a;

  // Character positions within one job. A header job walks from the colon;
  // a data job starts at the digit pair of the last byte slot.
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_COLON      = 4'd0;
  localparam step_t STEP_DATA_FIRST = 4'd7;
  localparam step_t STEP_BYTES_END  = 4'd8;
  localparam step_t STEP_LRC_HI     = 4'd9;
  localparam step_t STEP_LRC_LO     = 4'd10;
  localparam step_t STEP_CR         = 4'd11;
  localparam step_t STEP_LF         = 4'd12;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic            is_header;
    logic            last;
    logic [3:0][7:0] bytes;
    logic [7:0]      lrc;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] val;
    val = {4'h0, nib};
    if (nib < 4'd10) begin
      return 8'h30 + val;
    end else begin
      return 8'h57 + val;
    end
  endfunction

endpackage

// File: rtl/mbf_intf.sv
interface mbf_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        write_access;
  logic [15:0] start_register;
  logic [7:0]  data_byte;
  logic        last;

  modport source (output valid, mode, write_access, start_register, data_byte, last,
                  input ready);
  modport sink   (input valid, mode, write_access, start_register, data_byte, last,
                  output ready);
endinterface

interface mbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_char;

  modport source (output valid, ascii_char, last_char, input ready);
  modport sink   (input valid, ascii_char, last_char, output ready);
endinterface

interface mbf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] slave_address;

  modport source (output valid, slave_address, input ready);
  modport sink   (input valid, slave_address, output ready);
endinterface

// File: rtl/modbus_ascii_request_framer.sv
// Modbus ASCII request framer. A header word on in_i opens a frame and produces
// ':' followed by lower-case hex pairs for the slave address, the function code
// (03 for a read, 06 for a write) and the start register, high byte first. Each
// following data word produces its byte as two hex digits. A word with last set
// closes the frame by appending the LRC (two's complement of the byte sum) as
// two hex digits, then CR and LF; a header with last set is a complete frame.
// A data word with no frame open is accepted and dropped. A header while a
// frame is open abandons that frame and starts over. Every character leaves as
// one word on out_o, and last_char marks the final character of each input word.
// The output register sends one character per cycle while out_o is ready. A data
// word produces two characters (six when it closes the frame), a header nine
// (thirteen when it closes the frame). A two-entry job queue between the input
// side and the character generator takes input words while characters drain
// and while the output is stalled, until it is full. The slave address is
// written through cfg_i, which is always ready; write it only while the framer is idle.
module modbus_ascii_request_framer (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbf_in_if.sink    in_i,
  mbf_cfg_if.sink   cfg_i,
  mbf_out_if.source out_o
);
  import mbf_pkg::*;

  // Jobs from the classifier into the queue.
  job_t front_job;
  logic front_valid;
  logic front_ready;

  // Jobs from the queue head into the character generator.
  job_t back_job;
  logic back_valid;
  logic back_ready;

  // The classifier keeps the running sum and frame state and turns each header,
  // and each data word of an open frame, into a job holding its bytes and the LRC it would close with.
  mbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  mbf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_job_i   (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_job_o    (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // The generator walks each job one character per cycle into the output
  // register while the output is not stalled, and releases the job with its final character.
  mbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

// File: rtl/mbf_front.sv
module mbf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mbf_in_if.sink        in_i,
  mbf_cfg_if.sink       cfg_i,
  output mbf_pkg::job_t job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);
  import mbf_pkg::*;

  logic [7:0] slave_q, slave_d;
  logic [7:0] sum_q, sum_d;
  logic       open_q, open_d;

  logic       is_hdr;
  logic       accept;
  logic [7:0] func;
  logic [7:0] hdr_sum;
  logic [7:0] data_sum;
  logic [7:0] item_sum;

  assign cfg_i.ready = 1'b1;
  assign slave_d     = cfg_i.valid ? cfg_i.slave_address : slave_q;

  assign is_hdr   = (in_i.mode == MODE_HEADER);
  assign func     = in_i.write_access ? FUNC_WRITE : FUNC_READ;
  assign hdr_sum  = 8'(slave_q + func + in_i.start_register[15:8] + in_i.start_register[7:0]);
  assign data_sum = 8'(sum_q + in_i.data_byte);
  assign item_sum = is_hdr ? hdr_sum : data_sum;

  // A data word with no frame open is swallowed without producing a job.
  assign job_valid_o = in_i.valid && (is_hdr || open_q);
  assign in_i.ready  = job_ready_i || (!is_hdr && !open_q);
  assign accept      = in_i.valid && in_i.ready;

  always_comb begin
    job_o.is_header = is_hdr;
    job_o.last      = in_i.last;
    job_o.lrc       = 8'(8'h00 - item_sum);
    if (is_hdr) begin
      job_o.bytes[0] = slave_q;
      job_o.bytes[1] = func;
      job_o.bytes[2] = in_i.start_register[15:8];
      job_o.bytes[3] = in_i.start_register[7:0];
    end else begin
      job_o.bytes[0] = 8'h00;
      job_o.bytes[1] = 8'h00;
      job_o.bytes[2] = 8'h00;
      job_o.bytes[3] = in_i.data_byte;
    end
  end

  always_comb begin
    sum_d  = sum_q;
    open_d = open_q;
    if (accept && (is_hdr || open_q)) begin
      open_d = !in_i.last;
      sum_d  = in_i.last ? 8'h00 : item_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q <= 8'h00;
      sum_q   <= 8'h00;
      open_q  <= 1'b0;
    end else begin
      slave_q <= slave_d;
      sum_q   <= sum_d;
      open_q  <= open_d;
    end
  end

endmodule

// File: rtl/mbf_queue.sv
module mbf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mbf_pkg::job_t push_job_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output mbf_pkg::job_t pop_job_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);
  import mbf_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = push ? QPTR_W'(wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? QPTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = QCNT_W'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = QCNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/mbf_back.sv
module mbf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mbf_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  mbf_out_if.source     out_o
);
  import mbf_pkg::*;

  step_t      step_q, step_d;
  logic       busy_q, busy_d;
  logic       oval_q, oval_d;
  logic [7:0] char_q, char_d;
  logic       lchar_q, lchar_d;

  step_t      cur_step;
  step_t      step_m1;
  logic [7:0] cur_byte;
  logic [3:0] nib;
  logic [7:0] cur_char;
  logic       is_end;
  logic       advance;

  assign cur_step = busy_q ? step_q
                  : (job_i.is_header ? STEP_COLON : STEP_DATA_FIRST);
  assign step_m1  = STEP_W'(cur_step - 1'b1);
  assign cur_byte = (cur_step >= STEP_LRC_HI) ? job_i.lrc : job_i.bytes[step_m1[2:1]];
  // Odd positions carry the high nibble, both for the bytes and for the LRC.
  assign nib      = cur_step[0] ? cur_byte[7:4] : cur_byte[3:0];

  always_comb begin
    if (cur_step == STEP_COLON) begin
      cur_char = CHAR_COLON;
    end else if (cur_step == STEP_CR) begin
      cur_char = CHAR_CR;
    end else if (cur_step == STEP_LF) begin
      cur_char = CHAR_LF;
    end else begin
      cur_char = hex_char(nib);
    end
  end

  assign is_end      = ((cur_step == STEP_BYTES_END) && !job_i.last) || (cur_step == STEP_LF);
  assign advance     = job_valid_i && (!oval_q || out_o.ready);
  assign job_ready_o = advance && is_end;

  always_comb begin
    step_d  = step_q;
    busy_d  = busy_q;
    oval_d  = oval_q;
    char_d  = char_q;
    lchar_d = lchar_q;
    if (advance) begin
      oval_d  = 1'b1;
      char_d  = cur_char;
      lchar_d = is_end;
      busy_d  = !is_end;
      step_d  = STEP_W'(cur_step + 1'b1);
    end else if (out_o.ready) begin
      oval_d = 1'b0;
    end
  end

  assign out_o.valid      = oval_q;
  assign out_o.ascii_char = char_q;
  assign out_o.last_char  = lchar_q;

  always_ff @(posedge clk_i) begin
    char_q  <= char_d;
    lchar_q <= lchar_d;
    step_q  <= step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      oval_q <= oval_d;
    end
  end

endmodule

// File: tb/tb_modbus_ascii_request_framer.sv
module tb_modbus_ascii_request_framer;
  import mbf_pkg::*;

  // A run with no handshake on any channel for this many cycles is hung.
  localparam int unsigned HANG_LIMIT = 1000;
  // Cycles allowed for the framer to settle before a register write and at
  // the end. A closing header is 13 characters and the job queue holds two.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_WORDS = 150;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } frame_char_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mbf_in_if  in_if();
  mbf_cfg_if cfg_if();
  mbf_out_if out_if();

  modbus_ascii_request_framer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Characters the framer still owes, oldest first.
  frame_char_t frame_chars[$];

  // Shadow of the framer's state and its one register.
  logic [7:0] addr_shadow;
  logic [7:0] frame_sum;
  logic       frame_busy;

  // When set, neither side inserts idle cycles.
  bit          calm;
  int unsigned mismatches;
  int unsigned words_framed;
  int unsigned hang_cycles;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    logic [8*16-1:0] digits;
    digits = "0123456789abcdef";
    return digits[(15 - nib) * 8 +: 8];
  endfunction

  function automatic void emit_char(input logic [7:0] c);
    frame_chars.insert(frame_chars.size(), '{ch: c, fin: 1'b0});
  endfunction

  // Two hex digits, high nibble first. Frame bytes also enter the LRC sum.
  function automatic void emit_hex(input logic [7:0] b, input bit summed);
    emit_char(hex_ascii(b[7:4]));
    emit_char(hex_ascii(b[3:0]));
    if (summed) begin
      frame_sum = frame_sum + b;
    end
  endfunction

  // Appends the characters that one accepted word produces and returns how
  // many there are. A data word with no frame open produces nothing.
  function automatic int encode_word(input logic mode, input logic wr,
                                     input logic [15:0] reg_addr,
                                     input logic [7:0] dbyte, input logic last);
    int unsigned prev_count;
    prev_count = frame_chars.size();
    if (mode == MODE_HEADER) begin
      // A header always restarts the sum, abandoning any open frame.
      frame_sum  = 8'h00;
      frame_busy = 1'b1;
      emit_char(CHAR_COLON);
      emit_hex(addr_shadow, 1'b1);
      emit_hex(wr ? FUNC_WRITE : FUNC_READ, 1'b1);
      emit_hex(reg_addr[15:8], 1'b1);
      emit_hex(reg_addr[7:0], 1'b1);
    end else begin
      if (!frame_busy) begin
        return 0;
      end
      emit_hex(dbyte, 1'b1);
    end
    if (last) begin
      // The LRC is the two's complement of the running byte sum.
      emit_hex(8'h00 - frame_sum, 1'b0);
      emit_char(CHAR_CR);
      emit_char(CHAR_LF);
      frame_busy = 1'b0;
      frame_sum  = 8'h00;
    end
    frame_chars[$].fin = 1'b1;
    return frame_chars.size() - prev_count;
  endfunction

  // Sends one word on the request channel. It is entered and left just after
  // a falling edge; valid stays high on exit so that back-to-back words do
  // not drop it in between.
  task automatic send_word(input logic mode, input logic wr,
                           input logic [15:0] reg_addr, input logic [7:0] dbyte,
                           input logic last);
    bit done;
    done = 1'b0;
    while (!calm && $urandom_range(99) < 24) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid          = 1'b1;
    in_if.mode           = mode;
    in_if.write_access   = wr;
    in_if.start_register = reg_addr;
    in_if.data_byte      = dbyte;
    in_if.last           = last;
    while (!done) begin
      @(posedge clk_i);
      if (in_if.ready) begin
        done = 1'b1;
        // The first character can leave no earlier than the next edge, so
        // predicting here stays ahead of the result check.
        if (encode_word(mode, wr, reg_addr, dbyte, last) != 0) begin
          words_framed++;
        end
      end
    end
    @(negedge clk_i);
  endtask

  // Header and data words with the fields that their mode ignores randomized.
  task automatic send_header(input logic wr, input logic [15:0] reg_addr,
                             input logic last);
    send_word(MODE_HEADER, wr, reg_addr, 8'($urandom), last);
  endtask

  task automatic send_data(input logic [7:0] dbyte, input logic last);
    send_word(MODE_DATA, 1'($urandom), 16'($urandom), dbyte, last);
  endtask

  // Lets every owed character drain, then gives the framer time to finish a
  // dropped data word that leaves no result to wait for.
  task automatic settle;
    in_if.valid = 1'b0;
    while (frame_chars.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_slave_address(input logic [7:0] addr);
    bit done;
    done = 1'b0;
    settle();
    cfg_if.valid         = 1'b1;
    cfg_if.slave_address = addr;
    while (!done) begin
      @(posedge clk_i);
      if (cfg_if.ready) begin
        done        = 1'b1;
        addr_shadow = addr;
      end
    end
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Directed frames with the reset address of zero: field extremes, a header
  // that closes its own frame, a dropped data word and an LRC of zero.
  task automatic test_basic_frames;
    send_header(1'b0, 16'h0000, 1'b0);
    send_data(8'h00, 1'b0);
    send_data(8'hff, 1'b1);
    send_header(1'b1, 16'hffff, 1'b1);
    // No frame is open here, so this word is dropped even with last set.
    send_data(8'ha5, 1'b1);
    send_data(8'h3c, 1'b0);
    // 00 + 03 + 00 + fd wraps to zero, so the LRC is 00.
    send_header(1'b0, 16'h00fd, 1'b1);
  endtask

  // A header in the middle of a frame throws that frame away.
  task automatic test_abandoned_frame;
    send_header(1'b0, 16'h1234, 1'b0);
    send_data(8'h77, 1'b0);
    send_header(1'b1, 16'h8001, 1'b0);
    send_data(8'h01, 1'b1);
  endtask

  // Fields outside the word's mode must have no effect.
  task automatic test_ignored_fields;
    send_word(MODE_HEADER, 1'b0, 16'h5aa5, 8'hff, 1'b0);
    send_word(MODE_DATA, 1'b1, 16'hffff, 8'h5a, 1'b0);
    send_word(MODE_DATA, 1'b0, 16'h0000, 8'h00, 1'b1);
  endtask

  // The address register at both ends of its range and in between.
  task automatic test_address_extremes;
    write_slave_address(8'hff);
    send_header(1'b1, 16'h0000, 1'b0);
    send_data(8'hff, 1'b0);
    send_data(8'h80, 1'b1);
    write_slave_address(8'h5a);
    send_header(1'b0, 16'ha55a, 1'b1);
    write_slave_address(8'h00);
    send_header(1'b1, 16'h00ff, 1'b1);
  endtask

  // Mostly complete frames with random contents, mixed with stray data
  // words, frames left open for the next header to abandon, and one-word
  // frames. The address changes now and then, and one stretch runs with no
  // idling on either side.
  task automatic test_random_frames;
    int unsigned goal;
    int unsigned next_cfg;
    int unsigned pick;
    int unsigned count;
    goal     = words_framed + RANDOM_WORDS;
    next_cfg = words_framed + 40;
    while (words_framed < goal) begin
      calm = (words_framed > goal - 110) && (words_framed < goal - 70);
      if (words_framed >= next_cfg) begin
        write_slave_address(8'($urandom));
        next_cfg = words_framed + 40;
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
        count = $urandom_range(8);
        send_header(1'($urandom), 16'($urandom), count == 0);
        for (int unsigned i = 1; i <= count; i++) begin
          send_data(8'($urandom), i == count);
        end
      end else if (pick < 85) begin
        send_data(8'($urandom), 1'($urandom));
      end else if (pick < 95) begin
        count = $urandom_range(3);
        send_header(1'($urandom), 16'($urandom), 1'b0);
        for (int unsigned i = 0; i < count; i++) begin
          send_data(8'($urandom), 1'b0);
        end
      end else begin
        send_header(1'($urandom), 16'($urandom), 1'b1);
      end
    end
    calm = 1'b0;
  endtask

  // Output back-pressure, changed only at falling edges.
  initial out_if.ready = 1'b0;
  always @(negedge clk_i) begin
    out_if.ready = calm || ($urandom_range(99) >= 24);
  end

  // Every character is checked against the oldest owed one.
  always @(posedge clk_i) begin
    frame_char_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (frame_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h", out_if.ascii_char));
      end else begin
        want = frame_chars.pop_front();
        if (out_if.ascii_char !== want.ch) begin
          report_mismatch($sformatf("ascii_char %h, wanted %h",
                                    out_if.ascii_char, want.ch));
        end
        if (out_if.last_char !== want.fin) begin
          report_mismatch($sformatf("last_char %b, wanted %b on %h",
                                    out_if.last_char, want.fin, want.ch));
        end
      end
    end
  end

  // Ends a run in which no channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      hang_cycles = 0;
    end else begin
      hang_cycles++;
    end
    if (hang_cycles >= HANG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_if.valid          = 1'b0;
    in_if.mode           = MODE_HEADER;
    in_if.write_access   = 1'b0;
    in_if.start_register = 16'h0000;
    in_if.data_byte      = 8'h00;
    in_if.last           = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.slave_address = 8'h00;
    addr_shadow  = 8'h00;
    frame_sum    = 8'h00;
    frame_busy   = 1'b0;
    calm         = 1'b0;
    mismatches   = 0;
    words_framed = 0;
    hang_cycles  = 0;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_frames();
    test_abandoned_frame();
    test_ignored_fields();
    test_address_extremes();
    test_random_frames();

    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
